// ===== rtl/core/cst_pkg.sv =====
// Shared types and character constants for the character stream tokenizer.
`timescale 1ns / 1ps

package cst_pkg;

	// Input beat: one byte of text or an end-of-stream marker
	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_input;
	} in_beat_t;

	// Output beat: one token
	typedef struct packed {
		logic [15:0] tok_pos;
		logic [15:0] token_len;
		logic [1:0]  kind;
		logic [7:0]  first_char;
		logic [7:0]  second_char;
		logic        too_long;
	} out_beat_t;

	// Classification of the current byte against the pending operator
	typedef struct packed {
		logic is_sep;
		logic is_op;
		logic pair_ok;
	} char_class_t;

	// Token kinds
	localparam logic [1:0] KIND_WORD   = 2'd0;
	localparam logic [1:0] KIND_OP1    = 2'd1;
	localparam logic [1:0] KIND_OP2    = 2'd2;

	// Characters
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_BANG     = 8'h21;
	localparam logic [7:0] CH_AMP      = 8'h26;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_LT       = 8'h3C;
	localparam logic [7:0] CH_EQ       = 8'h3D;
	localparam logic [7:0] CH_GT       = 8'h3E;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_BAR      = 8'h7C;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;

	// Saturation limit of the word length counter
	localparam logic [15:0] LEN_SAT    = 16'hFFFF;

endpackage

// ===== rtl/core/cst_classify.sv =====
// Byte classifier: separator, operator, and two-character operator pairing.
`timescale 1ns / 1ps

module cst_classify (
	input  logic [7:0]          ch,
	input  logic [7:0]          pend_char,
	output cst_pkg::char_class_t cls
);
	import cst_pkg::*;

	always_comb begin
		cls.is_sep = (ch == CH_SPACE) || (ch == CH_NEWLINE);
		cls.is_op  = ch inside {CH_BANG, CH_LT, CH_GT, CH_SEMI, CH_EQ, CH_LBRACE,
		                        CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_AMP, CH_BAR};
		// <= >= != == join on '=', && and || join on themselves
		cls.pair_ok = ((pend_char inside {CH_LT, CH_GT, CH_BANG, CH_EQ}) && (ch == CH_EQ))
		           || ((pend_char == CH_AMP) && (ch == CH_AMP))
		           || ((pend_char == CH_BAR) && (ch == CH_BAR));
	end

endmodule

// ===== rtl/core/cst_lexer.sv =====
// Tokenizer state and token forming for one byte per step.
`timescale 1ns / 1ps

module cst_lexer #(
	parameter int MAX_WORD_LEN = 128,
	parameter int POS_BITS     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  cst_pkg::in_beat_t beat,
	output logic              emit,
	output cst_pkg::out_beat_t tok
);
	import cst_pkg::*;

	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [POS_BITS-1:0] start_q, start_d;
	logic [15:0]         len_q, len_d;
	logic                in_word_q, in_word_d;
	logic                pend_v_q, pend_v_d;
	logic [7:0]          pend_c_q, pend_c_d;
	char_class_t         cls;
	logic [31:0]         start_ext;
	logic                word_long;

	cst_classify u_classify (
		.ch        (beat.ch),
		.pend_char (pend_c_q),
		.cls       (cls)
	);

	assign start_ext = 32'(start_q);
	assign word_long = (len_q > 16'(MAX_WORD_LEN));

	// Next state and token
	always_comb begin
		pos_d     = pos_q;
		start_d   = start_q;
		len_d     = len_q;
		in_word_d = in_word_q;
		pend_v_d  = pend_v_q;
		pend_c_d  = pend_c_q;
		emit      = 1'b0;

		// word token by default; operator cases override
		tok.tok_pos     = start_ext[15:0];
		tok.token_len   = len_q;
		tok.kind        = KIND_WORD;
		tok.first_char  = '0;
		tok.second_char = '0;
		tok.too_long    = word_long;

		if (beat.end_of_input) begin
			// flush whatever is open, then clear everything
			if (pend_v_q) begin
				emit           = 1'b1;
				tok.token_len  = 16'd1;
				tok.kind       = KIND_OP1;
				tok.first_char = pend_c_q;
				tok.too_long   = 1'b0;
			end else if (in_word_q) begin
				emit = 1'b1;
			end
			pos_d     = '0;
			start_d   = '0;
			len_d     = '0;
			in_word_d = 1'b0;
			pend_v_d  = 1'b0;
			pend_c_d  = '0;
		end else begin
			pos_d = pos_q + POS_BITS'(1);
			if (pend_v_q) begin
				// pending operator leaves as a single or a pair
				pend_v_d       = 1'b0;
				emit           = 1'b1;
				tok.first_char = pend_c_q;
				tok.too_long   = 1'b0;
				if (cls.pair_ok) begin
					tok.token_len   = 16'd2;
					tok.kind        = KIND_OP2;
					tok.second_char = beat.ch;
				end else begin
					tok.token_len = 16'd1;
					tok.kind      = KIND_OP1;
				end
			end
			if (!(pend_v_q && cls.pair_ok)) begin
				if (cls.is_op) begin
					if (in_word_q) begin
						emit      = 1'b1;
						in_word_d = 1'b0;
					end
					pend_v_d = 1'b1;
					pend_c_d = beat.ch;
					start_d  = pos_q;
				end else if (cls.is_sep) begin
					if (in_word_q) begin
						emit      = 1'b1;
						in_word_d = 1'b0;
					end
				end else begin
					// word character: open a word if needed, count with saturation
					if (!in_word_q) begin
						in_word_d = 1'b1;
						start_d   = pos_q;
						len_d     = 16'd1;
					end else if (len_q != LEN_SAT) begin
						len_d = len_q + 16'd1;
					end
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			start_q   <= '0;
			len_q     <= '0;
			in_word_q <= 1'b0;
			pend_v_q  <= 1'b0;
			pend_c_q  <= '0;
		end else if (step) begin
			pos_q     <= pos_d;
			start_q   <= start_d;
			len_q     <= len_d;
			in_word_q <= in_word_d;
			pend_v_q  <= pend_v_d;
			pend_c_q  <= pend_c_d;
		end
	end

endmodule

// ===== rtl/core/char_stream_tokenizer.sv =====
// Top level of the character stream tokenizer: input register, lexer, result register.
//
//  channel | signals                        | direction | beat
//  --------+--------------------------------+-----------+----------------------------
//  in      | in_valid, in_ready, in_data    | sink      | one byte or end marker
//  out     | out_valid, out_ready, out_data | source    | one token (0 or 1 per byte)
//
// One byte per cycle sustained while the output is not stalled; a token is offered when
// its closing byte has gone from the input register through the lexer into the result
// register. The lexer classifies each byte and forms its next state combinationally.
// Reset clears the position, the open word and the pending operator.
// A stalled output holds the result register; the input register can still take one
// more beat if it is empty, after which in_ready drops until the result is taken.
`timescale 1ns / 1ps

module char_stream_tokenizer #(
	parameter int MAX_WORD_LEN = 128,
	parameter int POS_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cst_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output cst_pkg::out_beat_t out_data
);
	import cst_pkg::*;

	logic       valid_s1;
	in_beat_t   beat_s1;
	logic       advance;
	logic       emit;
	out_beat_t  tok;
	logic       out_valid_q;
	out_beat_t  out_q;

	// Byte in stage 1 moves on whenever the result register is empty or being taken
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= in_data;
		end
	end

	cst_lexer #(
		.MAX_WORD_LEN (MAX_WORD_LEN),
		.POS_BITS     (POS_BITS)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (beat_s1),
		.emit   (emit),
		.tok    (tok)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= tok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
